FILE: hw/rtl/psir_pkg.sv
package psir_pkg;

  // Capacity and field widths.
  localparam int MAX_ENTRIES   = 64;
  localparam int LINE_W        = 24;
  localparam int COLUMN_W      = 16;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 7;

  // Slot index and occupancy count widths follow from the capacity.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // The match reduction works on groups of eight cells.
  localparam int GRP_SIZE    = 8;
  localparam int GRP_W       = 3;
  localparam int NUM_GRPS    = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_ENTRIES = NUM_GRPS * GRP_SIZE;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_MERGE,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic                cmd;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_t;

  // One stored position: column in the upper bits, line in the lower bits.
  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [LINE_W-1:0]   line;
  } pos_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic             wr_en;
    logic             shift_en;
    logic [IDX_W-1:0] idx;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/psir_cell.sv
module psir_cell (
  input  logic                      clk,
  input  psir_pkg::cell_ctl_t       ctl,
  input  psir_pkg::pos_t            key,
  input  logic [psir_pkg::IDX_W-1:0] my_idx,
  input  logic [psir_pkg::CNT_W-1:0] count,
  input  psir_pkg::pos_t            nbr_entry,
  output psir_pkg::pos_t            entry,
  output logic                      match
);

  psir_pkg::pos_t entry_r;
  psir_pkg::pos_t entry_nxt;
  logic           match_r;
  logic           match_nxt;

  // A slot is occupied when its index is below the entry count.
  assign match_nxt = (psir_pkg::CNT_W'(my_idx) < count) && (entry_r == key);

  // Append writes the key into the first free slot; a remove pulls every
  // slot at or above the hit one place down from its upper neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.wr_en && (my_idx == ctl.idx)) begin
      entry_nxt = key;
    end else if (ctl.shift_en && (my_idx >= ctl.idx)) begin
      entry_nxt = nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

FILE: hw/rtl/psir_reduce.sv
module psir_reduce (
  input  logic                             clk,
  input  logic [psir_pkg::MAX_ENTRIES-1:0] match_vec,
  output logic                             hit,
  output logic [psir_pkg::IDX_W-1:0]       hit_idx
);

  logic [psir_pkg::PAD_ENTRIES-1:0] match_pad;
  logic [psir_pkg::NUM_GRPS-1:0]    grp_any_r;
  logic [psir_pkg::NUM_GRPS-1:0]    grp_any_nxt;
  logic [psir_pkg::GRP_W-1:0]       grp_idx_r   [psir_pkg::NUM_GRPS];
  logic [psir_pkg::GRP_W-1:0]       grp_idx_nxt [psir_pkg::NUM_GRPS];
  logic                             hit_r;
  logic                             hit_nxt;
  logic [psir_pkg::IDX_W-1:0]       idx_r;
  logic [psir_pkg::IDX_W-1:0]       idx_nxt;

  assign match_pad = psir_pkg::PAD_ENTRIES'(match_vec);

  // First level: per group of eight, any hit and the local position.
  // Entries are distinct, so at most one bit is set and OR-ing the
  // positions yields the index.
  always_comb begin
    for (int g = 0; g < psir_pkg::NUM_GRPS; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int j = 0; j < psir_pkg::GRP_SIZE; j++) begin
        if (match_pad[g*psir_pkg::GRP_SIZE + j]) begin
          grp_any_nxt[g] = 1'b1;
          grp_idx_nxt[g] = grp_idx_nxt[g] | psir_pkg::GRP_W'(j);
        end
      end
    end
  end

  // Second level: merge the group results into one hit flag and index.
  always_comb begin
    hit_nxt = |grp_any_r;
    idx_nxt = '0;
    for (int g = 0; g < psir_pkg::NUM_GRPS; g++) begin
      if (grp_any_r[g]) begin
        idx_nxt = idx_nxt |
                  psir_pkg::IDX_W'(g*psir_pkg::GRP_SIZE + int'(grp_idx_r[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_idx_r <= grp_idx_nxt;
    hit_r     <= hit_nxt;
    idx_r     <= idx_nxt;
  end

  assign hit     = hit_r;
  assign hit_idx = idx_r;

endmodule

FILE: hw/rtl/position_set_insert_remove_core.sv
// Ordered set of up to MAX_ENTRIES distinct (line, column) positions, held in
// a row of cells, one position per cell, packed from slot zero upward. Each
// command (add or remove) produces exactly one result with a status and the
// entry count after the command. The block works on one command at a time:
// a command passes through the MATCH, GROUP, MERGE and UPDATE states to its
// result, and the next command is taken in IDLE once the result is registered.
// UPDATE waits while a stalled result still holds the output register. The
// states cover the parallel compare in every cell, the two registered levels
// of the hit reduction and the update that appends or shifts the row. A
// finished result waits in the output register while a new command is taken.
// Reset empties the set at once; no clearing pass is needed.
module position_set_insert_remove_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  psir_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output psir_pkg::out_t out_data
);

  psir_pkg::state_t          state_r;
  psir_pkg::state_t          state_nxt;
  psir_pkg::in_t             req_r;
  logic [psir_pkg::CNT_W-1:0] cnt_r;
  logic [psir_pkg::CNT_W-1:0] cnt_nxt;
  logic                      out_valid_r;
  psir_pkg::out_t            out_data_r;
  logic                      load_out;
  psir_pkg::status_t         res_status;
  psir_pkg::cell_ctl_t       ctl;
  psir_pkg::pos_t            key;
  psir_pkg::pos_t            entries [psir_pkg::MAX_ENTRIES];
  logic [psir_pkg::MAX_ENTRIES-1:0] match_vec;
  logic                      hit;
  logic [psir_pkg::IDX_W-1:0] hit_idx;
  logic                      in_xfer;

  assign in_stall = (state_r != psir_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign key.line   = req_r.line;
  assign key.column = req_r.column;

  // Row of cells; each below the top takes its upper neighbor's entry on a shift, the top cell keeps its own.
  for (genvar i = 0; i < psir_pkg::MAX_ENTRIES; i++) begin : g_cell
    psir_pkg::pos_t nbr;
    if (i < psir_pkg::MAX_ENTRIES - 1) begin : g_mid
      assign nbr = entries[i+1];
    end else begin : g_last
      assign nbr = entries[i];
    end
    psir_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key),
      .my_idx    (psir_pkg::IDX_W'(i)),
      .count     (cnt_r),
      .nbr_entry (nbr),
      .entry     (entries[i]),
      .match     (match_vec[i])
    );
  end

  psir_reduce u_reduce (
    .clk       (clk),
    .match_vec (match_vec),
    .hit       (hit),
    .hit_idx   (hit_idx)
  );

  // Sequencer: compare, two reduction levels, then decide and update.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ctl        = '0;
    res_status = psir_pkg::ST_OK;
    load_out   = 1'b0;
    case (state_r)
      psir_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = psir_pkg::S_MATCH;
        end
      end
      psir_pkg::S_MATCH: begin
        state_nxt = psir_pkg::S_GROUP;
      end
      psir_pkg::S_GROUP: begin
        state_nxt = psir_pkg::S_MERGE;
      end
      psir_pkg::S_MERGE: begin
        state_nxt = psir_pkg::S_UPDATE;
      end
      psir_pkg::S_UPDATE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = psir_pkg::S_IDLE;
          if (req_r.cmd == psir_pkg::CMD_ADD) begin
            if ((req_r.line == '0) || (req_r.column == '0)) begin
              res_status = psir_pkg::ST_INVALID;
            end else if (hit) begin
              res_status = psir_pkg::ST_EXISTS;
            end else if (cnt_r == psir_pkg::CNT_W'(psir_pkg::MAX_ENTRIES)) begin
              res_status = psir_pkg::ST_FULL;
            end else begin
              ctl.wr_en = 1'b1;
              ctl.idx   = cnt_r[psir_pkg::IDX_W-1:0];
              cnt_nxt   = cnt_r + psir_pkg::CNT_W'(1);
            end
          end else if (hit) begin
            ctl.shift_en = 1'b1;
            ctl.idx      = hit_idx;
            cnt_nxt      = cnt_r - psir_pkg::CNT_W'(1);
          end else begin
            res_status = psir_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
        state_nxt = psir_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psir_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (load_out) begin
      out_data_r.status      <= res_status;
      out_data_r.entry_count <= psir_pkg::ENTRY_COUNT_W'(cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/psir_checker.sv
module psir_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input psir_pkg::out_t out_data,
  input logic           out_valid,
  input logic           out_stall
);

  // A result that is held off stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Only one command is in flight: a transfer in closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in flight");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= psir_pkg::STATUS_W'(psir_pkg::ST_NOT_FOUND))
    else $error("undefined status code");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <=
                  psir_pkg::ENTRY_COUNT_W'(psir_pkg::MAX_ENTRIES))
    else $error("entry count beyond capacity");

endmodule

bind position_set_insert_remove_core psir_checker u_psir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

FILE: tb/sv/tb_position_set_insert_remove_core.sv
`timescale 1ns / 1ps

module tb_position_set_insert_remove_core;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_SIZE = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  psir_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psir_pkg::out_t out_data;

  // Shadow copy of the set, kept in step with every accepted command.
  psir_pkg::pos_t shadow_store [psir_pkg::MAX_ENTRIES];
  int shadow_count = 0;
  psir_pkg::out_t expected_results [$];

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int error_cnt = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int status_hits [5] = '{default: 0};

  position_set_insert_remove_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow set and return the status and count it yields.
  function automatic psir_pkg::out_t apply_set_cmd(psir_pkg::in_t cmd_item);
    psir_pkg::pos_t key;
    psir_pkg::out_t res;
    psir_pkg::status_t st;
    int hit;
    int k;
    key.line = cmd_item.line;
    key.column = cmd_item.column;
    hit = shadow_count;
    for (k = 0; k < shadow_count; k++) begin
      if (shadow_store[k] == key) begin
        hit = k;
        break;
      end
    end
    if (cmd_item.cmd == psir_pkg::CMD_ADD) begin
      if (cmd_item.line == '0 || cmd_item.column == '0) begin
        st = psir_pkg::ST_INVALID;
      end else if (hit < shadow_count) begin
        st = psir_pkg::ST_EXISTS;
      end else if (shadow_count >= psir_pkg::MAX_ENTRIES) begin
        st = psir_pkg::ST_FULL;
      end else begin
        shadow_store[shadow_count] = key;
        shadow_count++;
        st = psir_pkg::ST_OK;
      end
    end else if (hit < shadow_count) begin
      // Close the gap so the remaining entries stay in insertion order.
      for (k = hit; k < shadow_count - 1; k++) begin
        shadow_store[k] = shadow_store[k + 1];
      end
      shadow_count--;
      st = psir_pkg::ST_OK;
    end else begin
      st = psir_pkg::ST_NOT_FOUND;
    end
    res.status = st;
    res.entry_count = psir_pkg::ENTRY_COUNT_W'(shadow_count);
    return res;
  endfunction

  // Predict on every input transfer and check every output transfer.
  always @(posedge clk) begin
    psir_pkg::out_t exp_res;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_set_cmd(in_data));
        cmds_sent++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding: status %0d, entry_count %0d",
                 out_data.status, out_data.entry_count);
          error_cnt++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.status <= psir_pkg::ST_NOT_FOUND) begin
            status_hits[exp_res.status]++;
          end
          if (out_data.status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_res.status, out_data.status);
            error_cnt++;
          end
          if (out_data.entry_count !== exp_res.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   exp_res.entry_count, out_data.entry_count);
            error_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog: give up when no transfer happens for too long.
  always @(negedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side backpressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Send one command; returns at the falling edge after its transfer with valid still high.
  task automatic send_cmd(psir_pkg::cmd_t op, logic [psir_pkg::LINE_W-1:0] ln,
                          logic [psir_pkg::COLUMN_W-1:0] col);
    psir_pkg::in_t item;
    item.cmd = op;
    item.line = ln;
    item.column = col;
    // Each cycle before the item goes out is idle with the given chance.
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // Zero coordinates on add, alone and together.
  task automatic test_invalid_args();
    send_cmd(psir_pkg::CMD_ADD, 24'd0, 16'd5);
    send_cmd(psir_pkg::CMD_ADD, 24'd3, 16'd0);
    send_cmd(psir_pkg::CMD_ADD, 24'd0, 16'd0);
    send_cmd(psir_pkg::CMD_ADD, 24'hFFFFFF, 16'd0);
  endtask

  // Extreme coordinates, duplicates, absent and zero removes, removal from the middle.
  task automatic test_add_remove();
    send_cmd(psir_pkg::CMD_ADD, 24'd1, 16'd1);
    send_cmd(psir_pkg::CMD_ADD, 24'hFFFFFF, 16'hFFFF);
    send_cmd(psir_pkg::CMD_ADD, 24'd1, 16'hFFFF);
    send_cmd(psir_pkg::CMD_ADD, 24'hFFFFFF, 16'd1);
    send_cmd(psir_pkg::CMD_ADD, 24'd1, 16'd1);
    send_cmd(psir_pkg::CMD_ADD, 24'hFFFFFF, 16'hFFFF);
    send_cmd(psir_pkg::CMD_REMOVE, 24'd2, 16'd2);
    send_cmd(psir_pkg::CMD_REMOVE, 24'd0, 16'd0);
    send_cmd(psir_pkg::CMD_REMOVE, 24'd0, 16'd1);
    send_cmd(psir_pkg::CMD_REMOVE, 24'hFFFFFF, 16'hFFFF);
    send_cmd(psir_pkg::CMD_REMOVE, 24'hFFFFFF, 16'hFFFF);
    send_cmd(psir_pkg::CMD_ADD, 24'hFFFFFF, 16'hFFFF);
    send_cmd(psir_pkg::CMD_REMOVE, 24'd1, 16'd1);
    send_cmd(psir_pkg::CMD_REMOVE, 24'd1, 16'hFFFF);
    send_cmd(psir_pkg::CMD_REMOVE, 24'hFFFFFF, 16'd1);
    send_cmd(psir_pkg::CMD_REMOVE, 24'hFFFFFF, 16'hFFFF);
    send_cmd(psir_pkg::CMD_REMOVE, 24'd1, 16'd1);
  endtask

  // Fill the set to capacity, probe the full set, then drain it in random order.
  task automatic test_full_set();
    psir_pkg::pos_t keys [$];
    psir_pkg::pos_t k;
    int i;
    int pick;
    for (i = 0; i < psir_pkg::MAX_ENTRIES; i++) begin
      k.line = psir_pkg::LINE_W'($urandom_range(1, 24'hFFFFFF));
      k.column = psir_pkg::COLUMN_W'($urandom_range(1, 16'hFFFF));
      keys.push_back(k);
      send_cmd(psir_pkg::CMD_ADD, k.line, k.column);
    end
    send_cmd(psir_pkg::CMD_ADD, psir_pkg::LINE_W'($urandom_range(1, 24'hFFFFFF)),
             psir_pkg::COLUMN_W'($urandom_range(1, 16'hFFFF)));
    send_cmd(psir_pkg::CMD_ADD, keys[10].line, keys[10].column);
    send_cmd(psir_pkg::CMD_ADD, 24'd0, keys[3].column);
    send_cmd(psir_pkg::CMD_REMOVE, keys[psir_pkg::MAX_ENTRIES-1].line,
             keys[psir_pkg::MAX_ENTRIES-1].column);
    send_cmd(psir_pkg::CMD_ADD, keys[psir_pkg::MAX_ENTRIES-1].line,
             keys[psir_pkg::MAX_ENTRIES-1].column);
    send_cmd(psir_pkg::CMD_REMOVE, keys[0].line, keys[0].column);
    send_cmd(psir_pkg::CMD_ADD, keys[0].line, keys[0].column);
    while (keys.size() > 0) begin
      pick = $urandom_range(keys.size() - 1);
      send_cmd(psir_pkg::CMD_REMOVE, keys[pick].line, keys[pick].column);
      keys.delete(pick);
    end
  endtask

  // Mostly commands on a small pool of positions so adds and removes hit each other;
  // the add share swings high and low so the set sweeps between empty and full.
  task automatic test_random_traffic(int n_items);
    psir_pkg::pos_t pool [POOL_SIZE];
    int i;
    int add_pct;
    int sel;
    logic [psir_pkg::LINE_W-1:0] ln;
    logic [psir_pkg::COLUMN_W-1:0] col;
    psir_pkg::cmd_t op;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool[i].line = psir_pkg::LINE_W'($urandom_range(1, 24'hFFFFFF));
      pool[i].column = psir_pkg::COLUMN_W'($urandom_range(1, 16'hFFFF));
    end
    pool[0].line = 24'hFFFFFF;
    pool[0].column = 16'hFFFF;
    pool[1].line = 24'd1;
    pool[1].column = 16'd1;
    add_pct = 85;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        add_pct = ((i / 100) % 2 == 0) ? 85 : 25;
      end
      sel = $urandom_range(99);
      if (sel < 85) begin
        sel = $urandom_range(POOL_SIZE - 1);
        op = ($urandom_range(99) < add_pct) ? psir_pkg::CMD_ADD : psir_pkg::CMD_REMOVE;
        send_cmd(op, pool[sel].line, pool[sel].column);
      end else begin
        // Noise: arbitrary coordinates, often with a zero in them.
        op = psir_pkg::cmd_t'($urandom_range(1));
        ln = psir_pkg::LINE_W'($urandom());
        col = psir_pkg::COLUMN_W'($urandom());
        sel = $urandom_range(2);
        if (sel == 0) ln = '0;
        if (sel == 1) col = '0;
        send_cmd(op, ln, col);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_gap_pct = 12;
    sink_stall_pct = 51;
    test_invalid_args();
    test_add_remove();
    test_full_set();
    test_random_traffic(200);

    src_gap_pct = 51;
    sink_stall_pct = 12;
    test_random_traffic(200);

    src_gap_pct = 0;
    sink_stall_pct = 0;
    test_full_set();
    test_random_traffic(200);

    in_valid <= 1'b0;
    while (expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() > 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_cnt++;
    end

    $display("Ran %0d commands and checked %0d results across three backpressure mixes.",
             cmds_sent, results_seen);
    $display("Statuses seen: ok %0d, invalid %0d, exists %0d, full %0d, not found %0d.",
             status_hits[psir_pkg::ST_OK], status_hits[psir_pkg::ST_INVALID],
             status_hits[psir_pkg::ST_EXISTS], status_hits[psir_pkg::ST_FULL],
             status_hits[psir_pkg::ST_NOT_FOUND]);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
